// ===== rtl/core/sca_pkg.sv =====
`default_nettype none
package sca_pkg;

  localparam int HIST_DEPTH = 4;
  localparam int HIST_W     = 9;
  localparam logic [HIST_W-1:0] EMPTY_MARK = 9'h1FF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HW_GROUP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_VOLUME = 2'd1;

  localparam logic [2:0] GRP_SIXTEEN_BIT = 3'd0;
  localparam logic [2:0] GRP_PREFIX_7A   = 3'd1;
  localparam logic [2:0] GRP_REPEAT      = 3'd2;
  localparam logic [2:0] GRP_DE          = 3'd3;
  localparam logic [2:0] GRP_DE32        = 3'd4;
  localparam logic [2:0] GRP_STAR        = 3'd5;
  localparam logic [2:0] GRP_NONE        = 3'd6;

  localparam logic [7:0] LEVEL_MAX = 8'd127;

  typedef struct packed {
    logic [HIST_DEPTH-1:0][HIST_W-1:0] hist;
    logic                              phase;
    logic                              filter;
    logic [7:0]                        held;
  } state_t;

  typedef struct packed {
    logic [2:0] hw_group;
    logic       rom_volume;
  } cfg_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [15:0] command;
    logic        stop_music;
    logic        volume_valid;
    logic [6:0]  volume_level;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sound_command_assembler_top.sv =====
// Sound command assembler.
// Input channel: one command byte per word on in_cmd_byte, valid/ready.
// Result channel: one word per input byte, valid/ready, carrying the
// assembled 16-bit command with its stop-music flag and, where a volume
// sequence completes, the new 7-bit volume level.
// Configuration channel: cfg_index selects hardware group (0) or ROM
// volume enable (1); other indexes are ignored. Always ready; write only
// while the block is idle.
// Flow: an accepted byte lands in the input register; its result is then
// registered when the result register can advance, and is shown from then on.
// Throughput: one byte per cycle unless the receiver stalls; the state update
// is a single pass of compare logic between the input and result registers.
// Reset: history filled with the empty marker, phase and filter clear,
// held byte 0xFF, group 0, ROM volume enabled, both channels empty.
// Receiver stall: the result register holds, an empty input register still
// takes one more byte, then in_ready drops until out_ready returns.
`default_nettype none
module sound_command_assembler_top (
  input  wire  logic                            clk,
  input  wire  logic                            rst_n,
  input  wire  logic                            in_valid,
  output logic                                  in_ready,
  input  wire  logic [7:0]                      in_cmd_byte,
  output logic                                  out_valid,
  input  wire  logic                            out_ready,
  output logic                                  out_cmd_valid,
  output logic [15:0]                           out_command,
  output logic                                  out_stop_music,
  output logic                                  out_volume_valid,
  output logic [6:0]                            out_volume_level,
  input  wire  logic                            cfg_valid,
  output logic                                  cfg_ready,
  input  wire  logic [sca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  logic [sca_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sca_pkg::cfg_t    cfg_r;
  sca_pkg::state_t  state_r, state_nxt;
  sca_pkg::result_t res_r, res_nxt;
  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic             out_valid_r;
  logic             advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hw_group   <= sca_pkg::GRP_SIXTEEN_BIT;
      cfg_r.rom_volume <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sca_pkg::CFG_HW_GROUP:   cfg_r.hw_group   <= cfg_data[2:0];
        sca_pkg::CFG_ROM_VOLUME: cfg_r.rom_volume <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sca_step u_step (
    .state_i  (state_r),
    .cfg_i    (cfg_r),
    .byte_i   (s1_byte_r),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_cmd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      state_r.hist   <= {sca_pkg::HIST_DEPTH{sca_pkg::EMPTY_MARK}};
      state_r.phase  <= 1'b0;
      state_r.filter <= 1'b0;
      state_r.held   <= 8'hFF;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cmd_valid    = res_r.cmd_valid;
  assign out_command      = res_r.command;
  assign out_stop_music   = res_r.stop_music;
  assign out_volume_valid = res_r.volume_valid;
  assign out_volume_level = res_r.volume_level;

endmodule
`default_nettype wire

// ===== rtl/core/sca_step.sv =====
`default_nettype none
module sca_step (
  input  wire  sca_pkg::state_t  state_i,
  input  wire  sca_pkg::cfg_t    cfg_i,
  input  wire  logic [7:0]       byte_i,
  output sca_pkg::state_t        state_o,
  output sca_pkg::result_t       result_o
);

  sca_pkg::state_t  st;
  sca_pkg::result_t res;
  logic [sca_pkg::HIST_W-1:0] c9, h1, h2, h3, inv9;
  logic             seq;
  logic             vol_hit;
  logic             clear;
  logic [15:0]      cmd;

  always_comb begin
    st    = state_i;
    res   = '0;
    vol_hit = 1'b0;
    clear = 1'b0;
    cmd   = '0;
    c9    = {1'b0, byte_i};
    inv9  = {1'b0, ~byte_i};

    st.phase = ~state_i.phase;
    st.hist[0] = c9;
    for (int i = 1; i < sca_pkg::HIST_DEPTH; i++) begin
      st.hist[i] = state_i.hist[i-1];
    end
    h1 = st.hist[1];
    h2 = st.hist[2];
    h3 = st.hist[3];
    seq = (h3 == 9'h055) && (h2 == 9'h0AA);

    case (cfg_i.hw_group)
      sca_pkg::GRP_SIXTEEN_BIT: begin
        if (seq || (h2 == '0 && h1 == '0 && byte_i == 8'h00)) begin
          if (seq && h1 == inv9 && cfg_i.rom_volume) begin
            vol_hit = 1'b1;
          end
          clear     = 1'b1;
          st.phase  = 1'b0;
          st.filter = 1'b1;
        end else begin
          st.filter = 1'b0;
        end
      end
      sca_pkg::GRP_PREFIX_7A: begin
        st.filter = 1'b0;
        if (h2 == 9'h079 && h1 == inv9) begin
          vol_hit   = cfg_i.rom_volume;
          clear     = 1'b1;
          st.phase  = 1'b0;
          st.filter = 1'b1;
        end else if (h1 == 9'h07A) begin
          st.held  = 8'h7A;
          st.phase = 1'b0;
        end else if (byte_i != 8'h7A) begin
          st.held  = 8'h00;
          st.phase = 1'b0;
        end else begin
          st.phase = 1'b1;
        end
      end
      sca_pkg::GRP_REPEAT: begin
        if (c9 != h1) begin
          st.held  = 8'h00;
          st.phase = 1'b0;
        end else begin
          st.phase = 1'b1;
        end
      end
      sca_pkg::GRP_DE, sca_pkg::GRP_DE32: begin
        if (byte_i != 8'hFF && byte_i != 8'h00) begin
          st.held  = 8'h00;
          st.phase = 1'b0;
        end else begin
          st.phase = 1'b1;
        end
        if (h1 == '0 && byte_i == 8'h00) begin
          st.held  = 8'h00;
          st.phase = 1'b0;
        end
      end
      sca_pkg::GRP_STAR: begin
        st.filter = 1'b0;
        if (h1 == 9'h0FE) begin
          if (byte_i inside {[8'h10:8'h2F]}) begin
            vol_hit   = cfg_i.rom_volume;
            clear     = 1'b1;
            st.phase  = 1'b0;
            st.filter = 1'b1;
          end else if (byte_i inside {[8'h01:8'h0F]}) begin
            st.held   = 8'h00;
            st.phase  = 1'b0;
            st.filter = 1'b1;
          end
        end
        if ((byte_i & 8'hFC) == 8'hFC) begin
          st.phase = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (vol_hit) begin
      res.volume_valid = 1'b1;
      res.volume_level = (h1 > {1'b0, sca_pkg::LEVEL_MAX}) ? sca_pkg::LEVEL_MAX[6:0] : h1[6:0];
    end

    if (clear) begin
      for (int i = 0; i < sca_pkg::HIST_DEPTH; i++) begin
        st.hist[i] = sca_pkg::EMPTY_MARK;
      end
    end

    if (st.filter || st.phase) begin
      st.held = byte_i;
    end else begin
      cmd           = {st.held, byte_i};
      res.cmd_valid = 1'b1;
      res.command   = cmd;
      case (cfg_i.hw_group)
        sca_pkg::GRP_SIXTEEN_BIT: res.stop_music = (cmd == 16'h03E3);
        sca_pkg::GRP_DE32:        res.stop_music = (cmd == 16'h0018) || (cmd == 16'h0023);
        sca_pkg::GRP_STAR:        res.stop_music = (cmd == 16'h0000) ||
                                                   ((cmd & 16'hF0FF) == 16'hF000);
        default:                  res.stop_music = 1'b0;
      endcase
    end

    state_o  = st;
    result_o = res;
  end

endmodule
`default_nettype wire
